/* rtl/vfcm_pkg.sv */
`timescale 1ns / 1ps

package vfcm_pkg;

	localparam int SIDE   = 16;
	localparam int HEIGHT = 64;
	localparam int NDIR   = 6;

	localparam int PX    = SIDE + 2;
	localparam int PY    = HEIGHT + 2;
	localparam int PZ    = SIDE + 2;
	localparam int DEPTH = PX * PY * PZ;

	localparam int ADDR_W  = $clog2(DEPTH);
	localparam int KIND_W  = 4;
	localparam int CNT_W   = 17;
	localparam int DIR_W   = 3;
	localparam int NSEL_W  = 3;
	localparam int FX_W    = 4;
	localparam int FY_W    = 6;
	localparam int FZ_W    = 4;

	localparam int CQ_DEPTH = 4;
	localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
	localparam int RQ_DEPTH = 8;
	localparam int RQ_PTR_W = $clog2(RQ_DEPTH);

	localparam logic [1:0] REQ_WRITE   = 2'd0;
	localparam logic [1:0] REQ_MESH    = 2'd1;
	localparam logic [1:0] REQ_RESTART = 2'd2;

	localparam logic [KIND_W-1:0] WATER_KIND_RST = 4'd5;

	localparam logic [ADDR_W-1:0] STEP_X = ADDR_W'(PY * PZ);
	localparam logic [ADDR_W-1:0] STEP_Y = ADDR_W'(PZ);
	localparam logic [ADDR_W-1:0] STEP_Z = ADDR_W'(1);

	typedef enum logic [1:0] {
		OP_WRITE,
		OP_MESH,
		OP_RESTART
	} cmd_op_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic [4:0] pos_x;
		logic [6:0] pos_y;
		logic [4:0] pos_z;
		logic [3:0] block_value;
	} in_item_t;

	typedef struct packed {
		logic [3:0]  face_x;
		logic [5:0]  face_y;
		logic [3:0]  face_z;
		logic [2:0]  face_dir;
		logic [3:0]  block_kind;
		logic        water_mesh;
		logic [16:0] face_index;
		logic        last;
	} res_t;

	typedef struct packed {
		cmd_op_t           op;
		logic [ADDR_W-1:0] addr;
		logic [KIND_W-1:0] value;
		logic [FX_W-1:0]   fx;
		logic [FY_W-1:0]   fy;
		logic [FZ_W-1:0]   fz;
	} cmd_t;

	function automatic logic [ADDR_W-1:0] cell_addr(input logic [4:0] x, input logic [6:0] y,
			input logic [4:0] z);
		logic [ADDR_W-1:0] xy;
		xy = ADDR_W'(ADDR_W'(x) * ADDR_W'(PY)) + ADDR_W'(y);
		return ADDR_W'(xy * ADDR_W'(PZ)) + ADDR_W'(z);
	endfunction

	// two's complement address step toward neighbour, order -x +x -y +y -z +z
	function automatic logic [ADDR_W-1:0] nb_offset(input logic [NSEL_W-1:0] d);
		logic [ADDR_W-1:0] off;
		case (d)
			3'd0: off = -STEP_X;
			3'd1: off = STEP_X;
			3'd2: off = -STEP_Y;
			3'd3: off = STEP_Y;
			3'd4: off = -STEP_Z;
			3'd5: off = STEP_Z;
			default: off = '0;
		endcase
		return off;
	endfunction

endpackage

/* rtl/vfcm_front.sv */
`timescale 1ns / 1ps

module vfcm_front import vfcm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	output logic     full,
	input  in_item_t item,
	input  logic     clearing,
	output logic     cmd_valid,
	input  logic     cmd_ready,
	output cmd_t     cmd
);

	cmd_t                cq_q [CQ_DEPTH];
	logic [CQ_PTR_W-1:0] wr_ptr_q;
	logic [CQ_PTR_W-1:0] rd_ptr_q;
	logic [CQ_PTR_W:0]   count_q;

	logic acc;
	logic keep;
	logic in_grid;
	logic in_interior;
	logic do_wr;
	logic do_rd;
	cmd_t new_cmd;

	assign full = (count_q == (CQ_PTR_W+1)'(CQ_DEPTH)) || clearing;
	assign acc  = push && !full;

	assign in_grid = (32'(item.pos_x) < PX) && (32'(item.pos_y) < PY) &&
		(32'(item.pos_z) < PZ);
	assign in_interior = (item.pos_x != '0) && (32'(item.pos_x) <= SIDE) &&
		(item.pos_y != '0) && (32'(item.pos_y) <= HEIGHT) &&
		(item.pos_z != '0) && (32'(item.pos_z) <= SIDE);

	// classify the transaction; out-of-grid writes, meshes outside the interior and unused request types are dropped here
	always_comb begin
		new_cmd.addr  = cell_addr(item.pos_x, item.pos_y, item.pos_z);
		new_cmd.value = item.block_value;
		new_cmd.fx    = FX_W'(item.pos_x - 5'd1);
		new_cmd.fy    = FY_W'(item.pos_y - 7'd1);
		new_cmd.fz    = FZ_W'(item.pos_z - 5'd1);
		new_cmd.op    = OP_WRITE;
		keep          = 1'b0;
		case (item.req_type)
			REQ_WRITE: begin
				new_cmd.op = OP_WRITE;
				keep       = in_grid;
			end
			REQ_MESH: begin
				new_cmd.op = OP_MESH;
				keep       = in_interior;
			end
			REQ_RESTART: begin
				new_cmd.op = OP_RESTART;
				keep       = 1'b1;
			end
			default: begin
				new_cmd.op = OP_WRITE;
				keep       = 1'b0;
			end
		endcase
	end

	assign do_wr     = acc && keep;
	assign cmd_valid = (count_q != '0);
	assign do_rd     = cmd_valid && cmd_ready;
	assign cmd       = cq_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			cq_q[wr_ptr_q] <= new_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/vfcm_back.sv */
`timescale 1ns / 1ps

module vfcm_back import vfcm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	input  cmd_t              cmd,
	input  logic [KIND_W-1:0] water_kind,
	input  logic              res_full,
	output logic              face_valid,
	output res_t              face,
	output logic              clearing
);

	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_READ  = 5'b00100,
		ST_EVAL  = 5'b01000,
		ST_EMIT  = 5'b10000
	} back_state_t;

	back_state_t       state_q;
	logic [ADDR_W-1:0] clr_addr_q;
	logic [NSEL_W-1:0] rd_cnt_q;
	cmd_t              cur_q;
	logic [KIND_W-1:0] kind_q;
	logic [KIND_W-1:0] nb_q [NDIR];
	logic [NDIR-1:0]   mask_q;
	logic              is_water_q;
	logic [CNT_W-1:0]  solid_q;
	logic [CNT_W-1:0]  water_q;

	logic [KIND_W-1:0] mem_q [DEPTH];
	logic [KIND_W-1:0] rdata_q;

	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [KIND_W-1:0] mem_wdata;
	logic [ADDR_W-1:0] rd_addr;
	logic              pop_cmd;
	logic              is_water;
	logic [NDIR-1:0]   vis;
	logic [NDIR-1:0]   pick;
	logic [NDIR-1:0]   rest;
	logic [DIR_W-1:0]  pick_dir;

	function automatic logic [DIR_W-1:0] enc_dir(input logic [NDIR-1:0] oh);
		logic [DIR_W-1:0] d;
		d = '0;
		for (int i = 0; i < NDIR; i++) begin
			if (oh[i]) begin
				d = DIR_W'(i);
			end
		end
		return d;
	endfunction

	assign clearing  = (state_q == ST_CLEAR);
	assign cmd_ready = (state_q == ST_IDLE);
	assign pop_cmd   = cmd_valid && cmd_ready;

	assign mem_we    = clearing || (pop_cmd && (cmd.op == OP_WRITE));
	assign mem_waddr = clearing ? clr_addr_q : cmd.addr;
	assign mem_wdata = clearing ? '0 : cmd.value;

	// step 0 reads the cell itself, steps 1..6 its neighbours
	assign rd_addr = (rd_cnt_q == '0) ? cur_q.addr :
		cur_q.addr + nb_offset(rd_cnt_q - 3'd1);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
		rdata_q <= mem_q[rd_addr];
	end

	assign is_water = (kind_q == water_kind);

	always_comb begin
		for (int i = 0; i < NDIR; i++) begin
			vis[i] = (kind_q != '0) && ((nb_q[i] == '0) ||
				(!is_water && (nb_q[i] == water_kind)));
		end
	end

	assign pick     = mask_q & (~mask_q + 1'b1);
	assign rest     = mask_q & ~pick;
	assign pick_dir = enc_dir(pick);

	assign face_valid = (state_q == ST_EMIT) && (mask_q != '0) && !res_full;

	always_comb begin
		face.face_x     = cur_q.fx;
		face.face_y     = cur_q.fy;
		face.face_z     = cur_q.fz;
		face.face_dir   = pick_dir;
		face.block_kind = kind_q;
		face.water_mesh = is_water_q;
		face.face_index = is_water_q ? water_q : solid_q;
		face.last       = (rest == '0);
	end

	always_ff @(posedge clk) begin
		if (pop_cmd) begin
			cur_q <= cmd;
		end
		if (state_q == ST_READ && rd_cnt_q != '0) begin
			if (rd_cnt_q == 3'd1) begin
				kind_q <= rdata_q;
			end else begin
				nb_q[rd_cnt_q - 3'd2] <= rdata_q;
			end
		end
		if (state_q == ST_EVAL) begin
			is_water_q <= is_water;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_addr_q <= '0;
			rd_cnt_q   <= '0;
			mask_q     <= '0;
			solid_q    <= '0;
			water_q    <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == ADDR_W'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (pop_cmd) begin
						case (cmd.op)
							OP_MESH: begin
								rd_cnt_q <= '0;
								state_q  <= ST_READ;
							end
							OP_RESTART: begin
								solid_q <= '0;
								water_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_READ: begin
					rd_cnt_q <= rd_cnt_q + 1'b1;
					if (rd_cnt_q == NSEL_W'(NDIR + 1)) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					mask_q  <= vis;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (mask_q == '0) begin
						state_q <= ST_IDLE;
					end else if (face_valid) begin
						mask_q <= rest;
						if (is_water_q) begin
							water_q <= water_q + 1'b1;
						end else begin
							solid_q <= solid_q + 1'b1;
						end
						if (rest == '0) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_no_cmd_while_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !cmd_ready)
		else $error("command taken during clearing pass");
	a_last_ends_cell: assert property (@(posedge clk) disable iff (!arst_n)
		face_valid && face.last |=> state_q == ST_IDLE)
		else $error("sequencer did not return to idle after last face");
	a_face_one_dir: assert property (@(posedge clk) disable iff (!arst_n)
		face_valid |-> $onehot(pick) && !res_full)
		else $error("face emitted without a single direction or with full queue");
`endif

endmodule

/* rtl/vfcm_res_queue.sv */
`timescale 1ns / 1ps

module vfcm_res_queue import vfcm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  res_t wr_data,
	output logic full,
	output logic empty,
	input  logic pop,
	output res_t head
);

	res_t                rq_q [RQ_DEPTH];
	logic [RQ_PTR_W-1:0] wr_ptr_q;
	logic [RQ_PTR_W-1:0] rd_ptr_q;
	logic [RQ_PTR_W:0]   count_q;
	logic                do_rd;

	assign full  = (count_q == (RQ_PTR_W+1)'(RQ_DEPTH));
	assign empty = (count_q == '0);
	assign do_rd = pop && !empty;
	assign head  = rq_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			rq_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_pop_drains: assert property (@(posedge clk) disable iff (!arst_n)
		do_rd && !wr |=> count_q == $past(count_q) - 1'b1)
		else $error("result count did not drop on pop");
`endif

endmodule

/* rtl/voxel_face_culling_mesher_unit.sv */
// writes and counter restarts leave the back end idle, ready for the next command
// a mesh transaction holds the back end for one voxel store read for the cell and six
// for its neighbours over the single read port, then one face a cycle while the result
// queue has room
// reset: async, active low; a clearing pass then zeroes the 21384-entry voxel store,
// one entry a cycle, with full held high until the pass is done
`timescale 1ns / 1ps

module voxel_face_culling_mesher_unit import vfcm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  in_item_t          item,
	output logic              empty,
	input  logic              pop,
	output res_t              result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [KIND_W-1:0] cfg_data
);

	logic [KIND_W-1:0] water_kind_q;
	logic              clearing;
	logic              cmd_valid;
	logic              cmd_ready;
	cmd_t              cmd;
	logic              res_full;
	logic              face_valid;
	res_t              face;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			water_kind_q <= WATER_KIND_RST;
		end else if (cfg_valid && cfg_ready) begin
			water_kind_q <= cfg_data;
		end
	end

	vfcm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.clearing  (clearing),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd)
	);

	vfcm_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_ready  (cmd_ready),
		.cmd        (cmd),
		.water_kind (water_kind_q),
		.res_full   (res_full),
		.face_valid (face_valid),
		.face       (face),
		.clearing   (clearing)
	);

	vfcm_res_queue u_res_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (face_valid),
		.wr_data (face),
		.full    (res_full),
		.empty   (empty),
		.pop     (pop),
		.head    (result)
	);

endmodule

/* sim/voxel_face_culling_mesher_unit_tb.sv */
`timescale 1ns / 1ps

module voxel_face_culling_mesher_unit_tb;
	import vfcm_pkg::*;

	localparam logic [1:0] REQ_UNUSED = 2'd3;

	typedef enum logic [2:0] {DIR_NX, DIR_PX, DIR_NY, DIR_PY, DIR_NZ, DIR_PZ} face_dir_e;

	typedef struct {
		in_item_t it;
		bit       typed;
		int       n_faces;
		res_t     first;
	} plan_row_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              push = 1'b0;
	logic              full;
	in_item_t          item = '0;
	logic              empty;
	logic              pop = 1'b0;
	res_t              result;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [KIND_W-1:0] cfg_data = '0;

	logic [3:0]  vox_model [DEPTH];
	logic [16:0] solid_next = '0;
	logic [16:0] water_next = '0;
	logic [3:0]  water_code = WATER_KIND_RST;
	res_t        faces_due [$];
	plan_row_t   plan [$];
	int          step_dx [NDIR] = '{-1, 1, 0, 0, 0, 0};
	int          step_dy [NDIR] = '{0, 0, -1, 1, 0, 0};
	int          step_dz [NDIR] = '{0, 0, 0, 0, -1, 1};
	int          row_faces;
	int          burst_left = 0;
	int          errs = 0;
	int          items_in = 0;
	int          faces_seen = 0;
	int          hold_ask = 0;
	bit          rx_free = 1'b0;
	logic [3:0]  mid_code;

	voxel_face_culling_mesher_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item     (item),
		.empty    (empty),
		.pop      (pop),
		.result   (result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#40_000_000;
		$display("tb: failure");
		$finish;
	end

	task automatic report(input string msg);
		errs++;
		if (errs <= 40) $display("mismatch: %s", msg);
	endtask

	function automatic int cell_index(input int x, input int y, input int z);
		return (x * PY + y) * PZ + z;
	endfunction

	function automatic in_item_t mk(input logic [1:0] op, input int x, input int y, input int z,
			input int v);
		in_item_t it;
		it.req_type    = op;
		it.pos_x       = 5'(x);
		it.pos_y       = 7'(y);
		it.pos_z       = 5'(z);
		it.block_value = 4'(v);
		return it;
	endfunction

	function automatic res_t face(input int x, input int y, input int z, input face_dir_e d,
			input int kind, input bit wet, input int idx);
		res_t f;
		f.face_x     = 4'(x);
		f.face_y     = 6'(y);
		f.face_z     = 4'(z);
		f.face_dir   = d;
		f.block_kind = 4'(kind);
		f.water_mesh = wet;
		f.face_index = 17'(idx);
		f.last       = 1'b0;
		return f;
	endfunction

	function automatic void add_row(input in_item_t it, input bit typed, input int n,
			input res_t first);
		plan_row_t r;
		r.it      = it;
		r.typed   = typed;
		r.n_faces = n;
		r.first   = first;
		plan.insert(plan.size(), r);
	endfunction

	// applies one transaction to the local grid and counters, queues the faces it shows
	function automatic int predict_faces(input in_item_t it);
		res_t       got [NDIR];
		int         n;
		int         x;
		int         y;
		int         z;
		logic [3:0] kind;
		logic [3:0] nb;
		bit         wet;
		bit         show;
		n = 0;
		x = it.pos_x;
		y = it.pos_y;
		z = it.pos_z;
		case (it.req_type)
			REQ_WRITE: begin
				if (x < PX && y < PY && z < PZ) vox_model[cell_index(x, y, z)] = it.block_value;
			end
			REQ_RESTART: begin
				solid_next = '0;
				water_next = '0;
			end
			REQ_MESH: begin
				if (x >= 1 && x <= SIDE && y >= 1 && y <= HEIGHT && z >= 1 && z <= SIDE) begin
					kind = vox_model[cell_index(x, y, z)];
					wet  = (kind == water_code);
					for (int d = 0; d < NDIR && kind != 0; d++) begin
						nb = vox_model[cell_index(x + step_dx[d], y + step_dy[d], z + step_dz[d])];
						show = wet ? (nb == 0) : (nb == 0 || nb == water_code);
						if (show) begin
							got[n] = face(x - 1, y - 1, z - 1, face_dir_e'(d), kind, wet,
								wet ? water_next : solid_next);
							if (wet) begin
								water_next = water_next + 1'b1;
							end else begin
								solid_next = solid_next + 1'b1;
							end
							n++;
						end
					end
				end
			end
			default: ;
		endcase
		for (int i = 0; i < n; i++) begin
			got[i].last = (i == n - 1);
			faces_due.insert(faces_due.size(), got[i]);
		end
		return n;
	endfunction

	task automatic offer(input in_item_t it);
		push <= 1'b1;
		item <= it;
		@(posedge clk);
		while (full) @(posedge clk);
		row_faces = predict_faces(it);
		items_in++;
	endtask

	task automatic pace();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
			if (gap > 0) begin
				push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
	endtask

	// mostly writes and meshes around two corners of the chunk, border included
	function automatic in_item_t rand_item();
		in_item_t it;
		int       r;
		int       bx;
		int       by;
		int       v;
		r  = $urandom_range(0, 99);
		bx = $urandom_range(0, 1) ? 12 : 0;
		by = (bx != 0) ? 60 : 0;
		v  = $urandom_range(0, 99);
		v  = (v < 30) ? 0 : (v < 55) ? water_code : $urandom_range(1, 15);
		if (r < 45)
			it = mk(REQ_WRITE, bx + $urandom_range(0, 5), by + $urandom_range(0, 5),
				bx + $urandom_range(0, 5), v);
		else if (r < 85)
			it = mk(REQ_MESH, bx + $urandom_range(1, 4), by + $urandom_range(1, 4),
				bx + $urandom_range(1, 4), $urandom_range(0, 15));
		else if (r < 88)
			it = mk(REQ_RESTART, $urandom_range(0, 31), $urandom_range(0, 127),
				$urandom_range(0, 31), $urandom_range(0, 15));
		else if (r < 91)
			it = mk(REQ_UNUSED, $urandom_range(0, 31), $urandom_range(0, 127),
				$urandom_range(0, 31), $urandom_range(0, 15));
		else
			it = in_item_t'(23'($urandom));
		return it;
	endfunction

	task automatic feed(input int count);
		repeat (count) begin
			offer(rand_item());
			pace();
		end
	endtask

	task automatic settle();
		push <= 1'b0;
		while (faces_due.size() != 0) @(posedge clk);
		repeat (64) @(posedge clk);
	endtask

	task automatic set_water_kind(input logic [3:0] k);
		cfg_valid <= 1'b1;
		cfg_data  <= k;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid  <= 1'b0;
		water_code = k;
	endtask

	task automatic check_face(input res_t got);
		res_t want;
		if (faces_due.size() == 0) begin
			report($sformatf("face %h arrived with nothing due", got));
		end else begin
			want = faces_due.pop_front();
			if (got.face_x !== want.face_x)
				report($sformatf("face_x %0d, want %0d", got.face_x, want.face_x));
			if (got.face_y !== want.face_y)
				report($sformatf("face_y %0d, want %0d", got.face_y, want.face_y));
			if (got.face_z !== want.face_z)
				report($sformatf("face_z %0d, want %0d", got.face_z, want.face_z));
			if (got.face_dir !== want.face_dir)
				report($sformatf("face_dir %0d, want %0d", got.face_dir, want.face_dir));
			if (got.block_kind !== want.block_kind)
				report($sformatf("block_kind %0d, want %0d", got.block_kind, want.block_kind));
			if (got.water_mesh !== want.water_mesh)
				report($sformatf("water_mesh %b, want %b", got.water_mesh, want.water_mesh));
			if (got.face_index !== want.face_index)
				report($sformatf("face_index %0d, want %0d", got.face_index, want.face_index));
			if (got.last !== want.last)
				report($sformatf("last %b, want %b", got.last, want.last));
		end
		faces_seen++;
	endtask

	// result side: random stall patterns, a long hold-off on request, free-running on request
	initial begin
		int hold_done;
		int hold_left;
		int pat_mode;
		int pat_left;
		hold_done = 0;
		hold_left = 0;
		pat_mode  = 4;
		pat_left  = 0;
		forever begin
			@(posedge clk);
			if (pop && !empty) check_face(result);
			if (hold_ask != hold_done) begin
				hold_done = hold_ask;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else if (rx_free) begin
				pop <= 1'b1;
			end else begin
				if (pat_left == 0) begin
					pat_mode = $urandom_range(1, 4);
					pat_left = $urandom_range(8, 64);
				end
				pat_left--;
				pop <= ($urandom_range(0, 3) < pat_mode);
			end
		end
	end

	initial begin
		foreach (vox_model[i]) vox_model[i] = '0;

		add_row(mk(REQ_MESH, 1, 1, 1, 0), 1'b1, 0, '0);
		add_row(mk(REQ_WRITE, 1, 1, 1, 15), 1'b1, 0, '0);
		add_row(mk(REQ_MESH, 1, 1, 1, 0), 1'b1, 6, face(0, 0, 0, DIR_NX, 15, 0, 0));
		add_row(mk(REQ_MESH, 0, 1, 1, 0), 1'b1, 0, '0);
		add_row(mk(REQ_MESH, 17, 65, 17, 0), 1'b1, 0, '0);
		add_row(mk(REQ_MESH, 31, 127, 31, 0), 1'b1, 0, '0);
		add_row(mk(REQ_WRITE, 31, 127, 31, 9), 1'b1, 0, '0);
		add_row(mk(REQ_WRITE, 2, 1, 1, 5), 1'b1, 0, '0);
		add_row(mk(REQ_WRITE, 1, 2, 1, 7), 1'b1, 0, '0);
		add_row(mk(REQ_MESH, 1, 1, 1, 0), 1'b0, 0, '0);
		add_row(mk(REQ_MESH, 2, 1, 1, 0), 1'b1, 5, face(1, 0, 0, DIR_PX, 5, 1, 0));
		// top neighbour layer and far corner
		add_row(mk(REQ_WRITE, 16, 65, 16, 3), 1'b1, 0, '0);
		add_row(mk(REQ_WRITE, 16, 64, 16, 12), 1'b1, 0, '0);
		add_row(mk(REQ_WRITE, 17, 64, 16, 5), 1'b1, 0, '0);
		add_row(mk(REQ_MESH, 16, 64, 16, 0), 1'b0, 0, '0);
		add_row(mk(REQ_RESTART, 0, 0, 0, 0), 1'b1, 0, '0);
		add_row(mk(REQ_MESH, 16, 64, 16, 0), 1'b1, 5,
			face(15, 63, 15, DIR_NX, 12, 0, 0));
		add_row(mk(REQ_UNUSED, 31, 127, 31, 15), 1'b1, 0, '0);
		// bury the corner cell on all six sides
		add_row(mk(REQ_WRITE, 0, 1, 1, 1), 1'b1, 0, '0);
		add_row(mk(REQ_WRITE, 1, 0, 1, 15), 1'b1, 0, '0);
		add_row(mk(REQ_WRITE, 1, 1, 0, 2), 1'b1, 0, '0);
		add_row(mk(REQ_WRITE, 1, 1, 2, 8), 1'b1, 0, '0);
		add_row(mk(REQ_WRITE, 2, 1, 1, 4), 1'b1, 0, '0);
		add_row(mk(REQ_MESH, 1, 1, 1, 0), 1'b1, 0, '0);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) begin
			offer(plan[i].it);
			if (plan[i].typed) begin
				if (row_faces != plan[i].n_faces)
					report($sformatf("row %0d: %0d faces, want %0d", i, row_faces,
						plan[i].n_faces));
				else if (row_faces > 0 && faces_due[faces_due.size() - row_faces] != plan[i].first)
					report($sformatf("row %0d: first face %h, want %h", i,
						faces_due[faces_due.size() - row_faces], plan[i].first));
			end
			pace();
		end
		settle();

		set_water_kind(4'd15);
		feed(10);
		offer(mk(REQ_WRITE, 6, 20, 6, 9));
		hold_ask <= hold_ask + 1;
		repeat (24) offer(mk(REQ_MESH, 6, 20, 6, 0));
		feed(6);
		settle();

		set_water_kind(4'd0);
		feed(17);
		push <= 1'b0;
		do @(posedge clk); while (faces_due.size() != 0);
		feed(18);
		settle();

		mid_code = 4'($urandom_range(1, 14));
		set_water_kind(mid_code);
		feed(8);
		settle();

		// a solid and a water cell meshed with the result side never stalling
		set_water_kind(WATER_KIND_RST);
		offer(mk(REQ_WRITE, 9, 30, 9, WATER_KIND_RST));
		rx_free <= 1'b1;
		offer(mk(REQ_MESH, 6, 20, 6, 0));
		offer(mk(REQ_MESH, 9, 30, 9, 0));
		push <= 1'b0;

		for (int w = 0; w < 100000 && faces_due.size() != 0; w++) @(posedge clk);
		repeat (64) @(posedge clk);
		if (faces_due.size() != 0) report($sformatf("%0d faces never arrived", faces_due.size()));

		$display("summary: %0d transactions in, %0d faces checked, %0d mismatches",
			items_in, faces_seen, errs);
		$display("summary: water kinds 5, 15, 0, %0d; long result stall; full drain pause",
			mid_code);
		if (errs == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
